### sv/psd_pkg.sv
// shared types and constants for the program stream packet deframer
`default_nettype none

package psd_pkg;

    localparam int POSITION_WIDTH_DEF = 48;
    localparam int OUT_POS_W          = 48;
    localparam int LEN_W              = 16;
    localparam int STAMP_W            = 32;

    localparam logic [7:0]  TYPE_PACK    = 8'hBA;
    localparam logic [7:0]  TYPE_PRIVATE = 8'hBC;
    localparam logic [7:0]  TYPE_BD      = 8'hBD;
    localparam logic [7:0]  TYPE_VIDEO   = 8'hE0;
    localparam logic [7:0]  START_ZERO   = 8'h00;
    localparam logic [7:0]  START_ONE    = 8'h01;
    localparam logic [23:0] START_PREFIX = 24'h000001;
    localparam logic [7:0]  MARK_FIRST   = 8'h48;
    localparam logic [7:0]  MARK_SECOND  = 8'h4B;
    localparam logic [LEN_W-1:0] PACK_LEN = 16'd16;

    // payload indexes that matter in a private packet
    localparam logic [LEN_W-1:0] IDX_MARK_A    = 16'd7;
    localparam logic [LEN_W-1:0] IDX_MARK_B    = 16'd23;
    localparam logic [LEN_W-1:0] IDX_STAMP_LO  = 16'd10;
    localparam logic [LEN_W-1:0] IDX_STAMP_HI  = 16'd13;
    localparam logic [LEN_W-1:0] IDX_SATURATE  = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_PACK    = 2'd0,
        KIND_PRIVATE = 2'd1,
        KIND_BD      = 2'd2,
        KIND_VIDEO   = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_HEAD = 5'b00010,
        PH_LENH = 5'b00100,
        PH_LENL = 5'b01000,
        PH_DATA = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0]           data_byte;
        t_kind                packet_kind;
        logic                 first_byte;
        logic                 last_byte;
        logic [OUT_POS_W-1:0] packet_position;
        logic                 stamp_valid;
        logic [STAMP_W-1:0]   stamp_raw;
    } t_result;

endpackage

`default_nettype wire

### sv/program_stream_packet_deframer_unit.sv
// top level of the program stream packet deframer
// a payload byte shows on the output in the cycle after its request is taken
// throughput: one stream byte per cycle unless the stalled output register is full
// header, length and hunt bytes are consumed without producing a result
// reset (synchronous, active low) returns the parser to hunting, clears the window,
// the stream position and the output valid flag; no sweep follows reset
`default_nettype none

module program_stream_packet_deframer_unit #(
    parameter int POSITION_WIDTH = psd_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input channel: one stream byte per request
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_stream_byte,
    // output channel: one payload byte per request
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [7:0]        o_data_byte,
    output logic [1:0]        o_packet_kind,
    output logic              o_first_byte,
    output logic              o_last_byte,
    output logic [47:0]       o_packet_position,
    output logic              o_stamp_valid,
    output logic [31:0]       o_stamp_raw
);
    import psd_pkg::*;

    t_result parse_result;
    t_result out_result;
    logic    parse_fire;
    logic    take;
    logic    full_stalled;

    // a request is taken whenever the result register can move
    assign o_stall = full_stalled;
    assign take    = i_valid && !full_stalled;

    psd_parser #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_stream_byte),
        .o_result (parse_result),
        .o_fire   (parse_fire)
    );

    // holds the finished result while the downstream side stalls
    psd_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (take),
        .i_fire         (parse_fire),
        .i_result       (parse_result),
        .i_stall        (i_stall),
        .o_full_stalled (full_stalled),
        .o_valid        (o_valid),
        .o_result       (out_result)
    );

    assign o_data_byte       = out_result.data_byte;
    assign o_packet_kind     = out_result.packet_kind;
    assign o_first_byte      = out_result.first_byte;
    assign o_last_byte       = out_result.last_byte;
    assign o_packet_position = out_result.packet_position;
    assign o_stamp_valid     = out_result.stamp_valid;
    assign o_stamp_raw       = out_result.stamp_raw;

endmodule

`default_nettype wire

### sv/psd_parser.sv
// per-byte parse state and next-state logic of the deframer
`default_nettype none

module psd_parser #(
    parameter int POSITION_WIDTH = psd_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_byte,
    output psd_pkg::t_result o_result,
    output logic             o_fire
);
    import psd_pkg::*;

    logic [23:0]               r_recent, n_recent;
    t_phase                    r_phase, n_phase;
    logic [1:0]                r_hcnt, n_hcnt;
    t_kind                     r_kind, n_kind;
    logic [LEN_W-1:0]          r_left, n_left;
    logic [LEN_W-1:0]          r_idx, n_idx;
    logic [1:0]                r_marks, n_marks;
    logic [STAMP_W-1:0]        r_stamp, n_stamp;
    logic [POSITION_WIDTH-1:0] r_pos, n_pos;
    logic [POSITION_WIDTH-1:0] r_start, n_start;

    logic             last;
    logic             mark_pair;
    logic [LEN_W-1:0] len;
    logic [63:0]      start_wide;

    assign last       = (r_left <= LEN_W'(1));
    assign mark_pair  = (r_recent[7:0] == MARK_FIRST) && (i_byte == MARK_SECOND);
    assign len        = {r_left[15:8], i_byte};
    assign start_wide = 64'(r_start);

    always_comb begin
        n_recent = {r_recent[15:0], i_byte};
        n_pos    = r_pos + POSITION_WIDTH'(1);
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_kind   = r_kind;
        n_left   = r_left;
        n_idx    = r_idx;
        n_marks  = r_marks;
        n_stamp  = r_stamp;
        n_start  = r_start;
        o_fire   = 1'b0;

        unique case (r_phase)
            PH_HUNT: begin
                if (r_hcnt == 2'd3 && r_recent == START_PREFIX && i_byte == TYPE_PACK) begin
                    n_start = r_pos - POSITION_WIDTH'(3);
                    n_kind  = KIND_PACK;
                    n_left  = PACK_LEN;
                    n_idx   = '0;
                    n_marks = '0;
                    n_stamp = '0;
                    n_phase = PH_DATA;
                    n_hcnt  = 2'd0;
                end else if (r_hcnt != 2'd3) begin
                    n_hcnt = r_hcnt + 2'd1;
                end
            end
            PH_HEAD: begin
                if (r_hcnt == 2'd0) begin
                    n_start = r_pos;
                end
                if (r_hcnt < 2'd2) begin
                    // a bad byte keeps the count: window stays usable up to here
                    if (i_byte == START_ZERO) n_hcnt = r_hcnt + 2'd1;
                    else n_phase = PH_HUNT;
                end else if (r_hcnt == 2'd2) begin
                    if (i_byte == START_ONE) n_hcnt = 2'd3;
                    else n_phase = PH_HUNT;
                end else begin
                    case (i_byte)
                        TYPE_PACK: begin
                            n_kind  = KIND_PACK;
                            n_left  = PACK_LEN;
                            n_idx   = '0;
                            n_marks = '0;
                            n_stamp = '0;
                            n_phase = PH_DATA;
                            n_hcnt  = 2'd0;
                        end
                        TYPE_PRIVATE, TYPE_BD, TYPE_VIDEO: begin
                            n_kind  = (i_byte == TYPE_PRIVATE) ? KIND_PRIVATE :
                                      (i_byte == TYPE_BD)      ? KIND_BD : KIND_VIDEO;
                            n_phase = PH_LENH;
                            n_hcnt  = 2'd0;
                        end
                        default: begin
                            n_phase = PH_HUNT;
                        end
                    endcase
                end
            end
            PH_LENH: begin
                n_left  = {i_byte, 8'h00};
                n_phase = PH_LENL;
            end
            PH_LENL: begin
                if (len == '0) begin
                    n_phase = PH_HUNT;
                    n_hcnt  = 2'd3;
                end else begin
                    n_left  = len;
                    n_idx   = '0;
                    n_marks = '0;
                    n_stamp = '0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                o_fire = 1'b1;
                if (r_kind == KIND_PRIVATE) begin
                    if (r_idx == IDX_MARK_A && mark_pair) n_marks[0] = 1'b1;
                    if (r_idx == IDX_MARK_B && mark_pair) n_marks[1] = 1'b1;
                    if (r_idx >= IDX_STAMP_LO && r_idx <= IDX_STAMP_HI) begin
                        n_stamp = {r_stamp[STAMP_W-9:0], i_byte};
                    end
                end
                if (r_idx != IDX_SATURATE) n_idx = r_idx + LEN_W'(1);
                if (last) begin
                    n_left  = '0;
                    n_phase = PH_HEAD;
                    n_hcnt  = 2'd0;
                end else begin
                    n_left = r_left - LEN_W'(1);
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_comb begin
        o_result.data_byte       = i_byte;
        o_result.packet_kind     = r_kind;
        o_result.first_byte      = (r_idx == '0);
        o_result.last_byte       = last;
        o_result.packet_position = start_wide[OUT_POS_W-1:0];
        o_result.stamp_valid     = last && (r_kind == KIND_PRIVATE) && (n_marks == 2'b11);
        o_result.stamp_raw       = o_result.stamp_valid ? n_stamp : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent <= '0;
            r_phase  <= PH_HUNT;
            r_hcnt   <= '0;
            r_kind   <= KIND_PACK;
            r_left   <= '0;
            r_idx    <= '0;
            r_marks  <= '0;
            r_stamp  <= '0;
            r_pos    <= '0;
            r_start  <= '0;
        end else if (i_take) begin
            r_recent <= n_recent;
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_kind   <= n_kind;
            r_left   <= n_left;
            r_idx    <= n_idx;
            r_marks  <= n_marks;
            r_stamp  <= n_stamp;
            r_pos    <= n_pos;
            r_start  <= n_start;
        end
    end

endmodule

`default_nettype wire

### sv/psd_out_reg.sv
// result register between the parser and the output channel
`default_nettype none

module psd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire logic             i_fire,
    input  psd_pkg::t_result      i_result,
    input  wire logic             i_stall,
    output logic                  o_full_stalled,
    output logic                  o_valid,
    output psd_pkg::t_result      o_result
);
    import psd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_full_stalled = r_valid && i_stall;
    assign o_valid        = r_valid;
    assign o_result       = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_full_stalled) begin
            r_valid <= i_load && i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_full_stalled && i_load && i_fire) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

### tb/psd_deframe_checker.sv
// watches both channels of the deframer, predicts its payload stream and counts mismatches
module psd_deframe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [1:0]  i_packet_kind,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [47:0] i_packet_position,
    input  logic        i_stamp_valid,
    input  logic [31:0] i_stamp_raw,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_payload_seen,
    output int          o_stamps_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import psd_pkg::*;

    // predicted parser state
    logic [23:0] scan_window;
    t_phase      parse_state;
    logic [1:0]  header_seen;
    t_kind       cur_kind;
    logic [15:0] bytes_to_go;
    logic [15:0] byte_index;
    logic [1:0]  marker_hits;
    logic [31:0] stamp_acc;
    logic [47:0] next_pos;
    logic [47:0] start_pos;

    t_result payload_expected[$];
    int      mismatch_count;
    int      payload_count;
    int      stamp_count;

    task automatic begin_payload(input t_kind kind, input logic [15:0] len);
        cur_kind    = kind;
        bytes_to_go = len;
        byte_index  = '0;
        marker_hits = '0;
        stamp_acc   = '0;
    endtask

    task automatic deframe_step(input logic [7:0] b);
        logic [7:0]  prev;
        logic [15:0] len;
        logic        fin;
        logic        stamp_ok;
        t_result     res;
        prev = scan_window[7:0];
        case (parse_state)
            PH_HUNT: begin
                if (header_seen == 2'd3 && scan_window == START_PREFIX && b == TYPE_PACK) begin
                    start_pos = next_pos - 48'd3;
                    begin_payload(KIND_PACK, PACK_LEN);
                    parse_state = PH_DATA;
                    header_seen = '0;
                end else if (header_seen != 2'd3) begin
                    header_seen = header_seen + 2'd1;
                end
            end
            PH_HEAD: begin
                if (header_seen == 2'd0) start_pos = next_pos;
                if (header_seen < 2'd2) begin
                    if (b == START_ZERO) header_seen = header_seen + 2'd1;
                    else parse_state = PH_HUNT;
                end else if (header_seen == 2'd2) begin
                    if (b == START_ONE) header_seen = 2'd3;
                    else parse_state = PH_HUNT;
                end else begin
                    case (b)
                        TYPE_PACK: begin
                            begin_payload(KIND_PACK, PACK_LEN);
                            parse_state = PH_DATA;
                            header_seen = '0;
                        end
                        TYPE_PRIVATE: begin
                            cur_kind    = KIND_PRIVATE;
                            parse_state = PH_LENH;
                            header_seen = '0;
                        end
                        TYPE_BD: begin
                            cur_kind    = KIND_BD;
                            parse_state = PH_LENH;
                            header_seen = '0;
                        end
                        TYPE_VIDEO: begin
                            cur_kind    = KIND_VIDEO;
                            parse_state = PH_LENH;
                            header_seen = '0;
                        end
                        default: parse_state = PH_HUNT;
                    endcase
                end
            end
            PH_LENH: begin
                bytes_to_go = {b, 8'h00};
                parse_state = PH_LENL;
            end
            PH_LENL: begin
                len = {bytes_to_go[15:8], b};
                if (len == '0) begin
                    parse_state = PH_HUNT;
                    header_seen = 2'd3;
                end else begin
                    begin_payload(cur_kind, len);
                    parse_state = PH_DATA;
                end
            end
            default: begin
                fin = (bytes_to_go <= 16'd1);
                if (cur_kind == KIND_PRIVATE) begin
                    if (byte_index == IDX_MARK_A && prev == MARK_FIRST && b == MARK_SECOND)
                        marker_hits[0] = 1'b1;
                    if (byte_index == IDX_MARK_B && prev == MARK_FIRST && b == MARK_SECOND)
                        marker_hits[1] = 1'b1;
                    if (byte_index >= IDX_STAMP_LO && byte_index <= IDX_STAMP_HI)
                        stamp_acc = {stamp_acc[23:0], b};
                end
                stamp_ok = fin && cur_kind == KIND_PRIVATE && marker_hits == 2'b11;
                res.data_byte       = b;
                res.packet_kind     = cur_kind;
                res.first_byte      = (byte_index == '0);
                res.last_byte       = fin;
                res.packet_position = start_pos;
                res.stamp_valid     = stamp_ok;
                res.stamp_raw       = stamp_ok ? stamp_acc : '0;
                payload_expected.push_back(res);
                if (byte_index != IDX_SATURATE) byte_index = byte_index + 16'd1;
                if (fin) begin
                    bytes_to_go = '0;
                    parse_state = PH_HEAD;
                    header_seen = '0;
                end else begin
                    bytes_to_go = bytes_to_go - 16'd1;
                end
            end
        endcase
        scan_window = {scan_window[15:0], b};
        next_pos    = next_pos + 48'd1;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            scan_window = '0;
            parse_state = PH_HUNT;
            header_seen = '0;
            cur_kind    = KIND_PACK;
            bytes_to_go = '0;
            byte_index  = '0;
            marker_hits = '0;
            stamp_acc   = '0;
            next_pos    = '0;
            start_pos   = '0;
            payload_expected.delete();
        end else begin
            // a result leaving now comes from an earlier request, so compare first
            if (i_out_valid && !i_out_stall) begin
                got.data_byte       = i_data_byte;
                got.packet_kind     = t_kind'(i_packet_kind);
                got.first_byte      = i_first_byte;
                got.last_byte       = i_last_byte;
                got.packet_position = i_packet_position;
                got.stamp_valid     = i_stamp_valid;
                got.stamp_raw       = i_stamp_raw;
                if (payload_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected payload byte %h at %0t, nothing was due",
                                 got.data_byte, $realtime);
                end else begin
                    want = payload_expected.pop_front();
                    if (got.data_byte !== want.data_byte ||
                        got.packet_kind !== want.packet_kind ||
                        got.first_byte !== want.first_byte ||
                        got.last_byte !== want.last_byte ||
                        got.packet_position !== want.packet_position ||
                        got.stamp_valid !== want.stamp_valid ||
                        got.stamp_raw !== want.stamp_raw) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("payload mismatch at %0t", $realtime);
                            $display("  expected byte %h kind %0d first %b last %b pos %h stamp %b %h",
                                     want.data_byte, want.packet_kind, want.first_byte,
                                     want.last_byte, want.packet_position, want.stamp_valid,
                                     want.stamp_raw);
                            $display("  actual   byte %h kind %0d first %b last %b pos %h stamp %b %h",
                                     got.data_byte, got.packet_kind, got.first_byte,
                                     got.last_byte, got.packet_position, got.stamp_valid,
                                     got.stamp_raw);
                        end
                    end else if (got.stamp_valid) begin
                        stamp_count++;
                    end
                    payload_count++;
                end
            end
            if (i_in_valid && !i_in_stall) deframe_step(i_in_byte);
        end
        o_mismatches   <= mismatch_count;
        o_pending      <= payload_expected.size();
        o_payload_seen <= payload_count;
        o_stamps_seen  <= stamp_count;
    end

endmodule

### tb/program_stream_packet_deframer_unit_tb.sv
// stimulus and verdict for the program stream packet deframer
module program_stream_packet_deframer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psd_pkg::*;

    localparam int     ITEM_TARGET   = 1950;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     SETTLE_CYCLES = 16;
    // far above the slowest correct run
    localparam longint RUN_LIMIT_NS  = 2_000_000;

    // traffic shapes that the run rotates through
    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SLOW_SOURCE,
        FLOW_SLOW_SINK,
        FLOW_LIGHT_BOTH
    } t_flow;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [7:0] i_stream_byte = 8'h00;
    logic i_stall = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_data_byte;
    logic [1:0]  o_packet_kind;
    logic        o_first_byte;
    logic        o_last_byte;
    logic [47:0] o_packet_position;
    logic        o_stamp_valid;
    logic [31:0] o_stamp_raw;

    int    mismatches;
    int    pending;
    int    payload_seen;
    int    stamps_seen;
    int    bytes_sent = 0;
    t_flow flow = FLOW_FREE;
    // the stimulus asks for a long sink hold-off, the sink side serves it
    int    hold_requests = 0;
    int    hold_served = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    program_stream_packet_deframer_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_stream_byte     (i_stream_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_data_byte       (o_data_byte),
        .o_packet_kind     (o_packet_kind),
        .o_first_byte      (o_first_byte),
        .o_last_byte       (o_last_byte),
        .o_packet_position (o_packet_position),
        .o_stamp_valid     (o_stamp_valid),
        .o_stamp_raw       (o_stamp_raw)
    );

    psd_deframe_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_in_byte         (i_stream_byte),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_data_byte       (o_data_byte),
        .i_packet_kind     (o_packet_kind),
        .i_first_byte      (o_first_byte),
        .i_last_byte       (o_last_byte),
        .i_packet_position (o_packet_position),
        .i_stamp_valid     (o_stamp_valid),
        .i_stamp_raw       (o_stamp_raw),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_payload_seen    (payload_seen),
        .o_stamps_seen     (stamps_seen)
    );

    // one stream byte per request; called at a falling edge, returns at the falling
    // edge after the request was taken with valid still up for the next call to decide
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap_pct;
        gap_pct = (flow == FLOW_SLOW_SOURCE) ? 57 : (flow == FLOW_LIGHT_BOTH) ? 8 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_stream_byte <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // source goes quiet until every predicted payload byte has left the block
    task automatic wait_for_payload_drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // bytes biased toward start code material so that partial codes show up often
    function automatic logic [7:0] stream_noise();
        case ($urandom_range(7))
            0, 1: return START_ZERO;
            2: return START_ONE;
            3: return TYPE_PACK;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly short packets, a few long enough to exercise the high length byte
    function automatic logic [15:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 2) return 16'($urandom_range(256, 280));
        if (roll < 30) return 16'($urandom_range(25, 64));
        return 16'($urandom_range(1, 24));
    endfunction

    // one of the types that carry a length field
    function automatic logic [7:0] length_type();
        case ($urandom_range(2))
            0: return TYPE_PRIVATE;
            1: return TYPE_BD;
            default: return TYPE_VIDEO;
        endcase
    endfunction

    // full packet: start code, type, length where the type has one, payload;
    // marks places the 48 4B pair at bytes 6-7 (bit 0) and 22-23 (bit 1)
    task automatic send_packet(input logic [7:0] type_code, input logic [15:0] len,
                               input logic [1:0] marks);
        logic [7:0] value;
        send_byte(START_ZERO);
        send_byte(START_ZERO);
        send_byte(START_ONE);
        send_byte(type_code);
        if (type_code != TYPE_PACK) begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        for (int i = 0; i < int'(len); i++) begin
            value = ($urandom_range(7) == 0) ? stream_noise() : 8'($urandom);
            if ((marks[0] && i == int'(IDX_MARK_A) - 1) ||
                (marks[1] && i == int'(IDX_MARK_B) - 1))
                value = MARK_FIRST;
            if ((marks[0] && i == int'(IDX_MARK_A)) || (marks[1] && i == int'(IDX_MARK_B)))
                value = MARK_SECOND;
            send_byte(value);
        end
    endtask

    // sink side: random stalls by traffic shape, plus the long hold-off on request
    initial begin : sink_side
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                // output register fills up and the block must push back on the source
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                case (flow)
                    FLOW_SLOW_SINK:  i_stall <= ($urandom_range(99) < 57);
                    FLOW_LIGHT_BOTH: i_stall <= ($urandom_range(99) < 8);
                    default:         i_stall <= 1'b0;
                endcase
            end
        end
    end

    initial begin : stimulus
        // hunt slides past a stray FF, then a pack whose payload hides a start code,
        // then a video header with zero length that must drop the lock
        static logic [7:0] opening [27] = '{
            8'hFF, START_ZERO, START_ZERO, START_ONE, TYPE_PACK,
            8'h00, 8'hFF, 8'h01, 8'hBA, 8'h48, 8'h4B, 8'h80, 8'h7F,
            8'h55, 8'hAA, 8'h00, 8'h00, 8'h01, 8'hBA, 8'h10, 8'h20,
            START_ZERO, START_ZERO, START_ONE, TYPE_VIDEO, 8'h00, 8'h00
        };
        logic [7:0] odd_byte;
        logic [1:0] marks;
        int         segment;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (opening[i]) send_byte(opening[i]);

        segment = 0;
        while (bytes_sent < ITEM_TARGET) begin
            // rotate traffic shape every few segments so gaps land everywhere
            flow = t_flow'((segment / 5) % 4);
            if (segment == 12) hold_requests++;
            if (segment == 8) wait_for_payload_drain();

            if ($urandom_range(99) < 70) begin
                // locked run: a pack to gain sync, then back-to-back packets
                send_packet(TYPE_PACK, PACK_LEN, 2'b00);
                repeat ($urandom_range(1, 5)) begin
                    case ($urandom_range(3))
                        0: send_packet(TYPE_PACK, PACK_LEN, 2'b00);
                        1: begin
                            marks = ($urandom_range(1) != 0) ? 2'b11 : 2'($urandom_range(2));
                            // a stamp needs 24 payload bytes; short ones must never report
                            if (marks == 2'b11 && $urandom_range(3) != 0)
                                send_packet(TYPE_PRIVATE, 16'($urandom_range(24, 40)), marks);
                            else
                                send_packet(TYPE_PRIVATE, pick_length(), marks);
                        end
                        2: send_packet(TYPE_BD, pick_length(), 2'b00);
                        default: send_packet(TYPE_VIDEO, pick_length(), 2'b00);
                    endcase
                end
                // how the run ends: cleanly, or with a header broken at some byte
                case ($urandom_range(5))
                    0: begin
                        // next segment follows directly
                    end
                    1: send_byte(8'($urandom_range(1, 255)));
                    2: begin
                        send_byte(START_ZERO);
                        send_byte(8'($urandom_range(1, 255)));
                    end
                    3: begin
                        send_byte(START_ZERO);
                        send_byte(START_ZERO);
                        do odd_byte = 8'($urandom); while (odd_byte == START_ONE);
                        send_byte(odd_byte);
                    end
                    4: begin
                        // unknown type after a good start code
                        send_byte(START_ZERO);
                        send_byte(START_ZERO);
                        send_byte(START_ONE);
                        do odd_byte = 8'($urandom);
                        while (odd_byte == TYPE_PACK || odd_byte == TYPE_PRIVATE ||
                               odd_byte == TYPE_BD || odd_byte == TYPE_VIDEO);
                        send_byte(odd_byte);
                    end
                    default: begin
                        // zero length on a type that carries one
                        send_byte(START_ZERO);
                        send_byte(START_ZERO);
                        send_byte(START_ONE);
                        send_byte(length_type());
                        send_byte(8'h00);
                        send_byte(8'h00);
                    end
                endcase
            end else if ($urandom_range(1) != 0) begin
                // loose noise, may or may not form a start code
                repeat ($urandom_range(1, 8)) send_byte(stream_noise());
            end else begin
                // a bare start code and type; in the hunt only a pack type ends it
                send_byte(START_ZERO);
                send_byte(START_ZERO);
                send_byte(START_ONE);
                send_byte(($urandom_range(1) != 0) ? length_type() : 8'($urandom));
            end
            segment++;
        end

        // let everything out, then a short settle for the registered output stage
        flow = FLOW_FREE;
        wait_for_payload_drain();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d stream bytes in %0d segments, %0d payload bytes checked, %0d stamps",
                 bytes_sent, segment, payload_seen, stamps_seen);
        $display("traffic: free, slow source, slow sink, light both ways, %0d long hold-off(s)",
                 hold_served);
        if (mismatches == 0 && pending == 0) begin
            $display("[program_stream_packet_deframer_unit] OK");
        end else begin
            $display("[program_stream_packet_deframer_unit] ERROR");
        end
        $finish;
    end

    // run limit in case the block hangs
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("run limit reached with %0d payload bytes still due", pending);
        $display("[program_stream_packet_deframer_unit] ERROR");
        $finish;
    end

endmodule
